// File: rtl/point_segment_projection_distance_unit_assert.svh
// assertion macros used by the port checker file of the projection unit
// depends on signals named clk and arst_n in the including module
`ifndef POINT_SEGMENT_PROJECTION_DISTANCE_UNIT_ASSERT_SVH
`define POINT_SEGMENT_PROJECTION_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/psp_pkg.sv
// shared types and constants of the point-to-segment projection unit
// no dependencies
package psp_pkg;

	// bits of the projection fraction t/b
	localparam int FRAC_BITS = 32;

	// which case produced the nearest point
	typedef enum logic [1:0] {
		REGION_START    = 2'd0,
		REGION_END      = 2'd1,
		REGION_INTERIOR = 2'd2
	} region_t;

endpackage

// File: rtl/point_segment_projection_distance_unit.sv
// Nearest point on a 3D segment to a query point, plus the truncated Euclidean
// distance; points in signed Q16.16 at COORD_WIDTH bits, distance unsigned at
// COORD_WIDTH + 1 bits. One beat in, one beat out, in order. The pipeline takes a new
// beat every cycle while the result side does not stall. It has five stages for
// differences, dot products and the clamp decision, 32 stages of the fraction divider,
// four stages for the interpolation and squared distance, COORD_WIDTH + 1 stages of
// the square root and the output register. The whole pipeline advances when the output
// register is empty or being taken, so a stall on the result side holds every stage.
// depends on psp_pkg, psp_divider, psp_isqrt
module point_segment_projection_distance_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z, zero pad
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// near_x, near_y, near_z, gap, zero pad
	output logic [((4*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata,
	// region
	output logic [1:0] m_axis_tuser
);

	localparam int W        = COORD_WIDTH;
	localparam int V        = W + 1;
	localparam int P        = 2 * V;
	localparam int B        = 2 * W + 2;
	localparam int T        = B + 2;
	localparam int N        = W + 1;
	localparam int DIV      = psp_pkg::FRAC_BITS;
	localparam int FW       = DIV + 1 + V;
	localparam int LAT      = 5 + DIV + 4 + N + 1;
	localparam int OUT_BITS = ((4*COORD_WIDTH+8)/8)*8;

	logic en;
	logic [LAT-1:0] vld_q;

	// global advance: output empty or taken
	assign en            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	// valid bits travel with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	logic signed [W-1:0] s_s1 [3], e_s1 [3], q_s1 [3];
	logic signed [W-1:0] s_s2 [3], e_s2 [3], q_s2 [3];
	logic signed [V-1:0] v_s2 [3], r_s2 [3];
	logic signed [W-1:0] s_s3 [3], e_s3 [3], q_s3 [3];
	logic signed [V-1:0] v_s3 [3];
	logic signed [P-1:0] rv_s3 [3];
	logic [P-1:0]        vv_s3 [3];
	logic signed [W-1:0] s_s4 [3], e_s4 [3], q_s4 [3];
	logic signed [V-1:0] v_s4 [3];
	logic signed [T-1:0] t_s4;
	logic [B-1:0]        b_s4;
	logic signed [W-1:0] base_s5 [3], q_s5 [3];
	logic signed [V-1:0] v_s5 [3];
	psp_pkg::region_t    region_s5;
	logic [B-1:0]        num_s5, den_s5;
	logic                t_pos, t_ge;

	// stage 1: unpack input beat
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= s_axis_tdata[i*W +: W];
				e_s1[i] <= s_axis_tdata[(3+i)*W +: W];
				q_s1[i] <= s_axis_tdata[(6+i)*W +: W];
			end
		end
	end

	// stage 2: segment and query vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s2[i] <= V'(e_s1[i]) - V'(s_s1[i]);
				r_s2[i] <= V'(q_s1[i]) - V'(s_s1[i]);
				s_s2[i] <= s_s1[i];
				e_s2[i] <= e_s1[i];
				q_s2[i] <= q_s1[i];
			end
		end
	end

	// stage 3: per-axis products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rv_s3[i] <= r_s2[i] * v_s2[i];
				vv_s3[i] <= P'(v_s2[i] * v_s2[i]);
				v_s3[i]  <= v_s2[i];
				s_s3[i]  <= s_s2[i];
				e_s3[i]  <= e_s2[i];
				q_s3[i]  <= q_s2[i];
			end
		end
	end

	// stage 4: dot products t = r.v and b = v.v
	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= T'(rv_s3[0]) + T'(rv_s3[1]) + T'(rv_s3[2]);
			b_s4 <= B'(vv_s3[0]) + B'(vv_s3[1]) + B'(vv_s3[2]);
			for (int i = 0; i < 3; i++) begin
				v_s4[i] <= v_s3[i];
				s_s4[i] <= s_s3[i];
				e_s4[i] <= e_s3[i];
				q_s4[i] <= q_s3[i];
			end
		end
	end

	// stage 5: clamp decision
	assign t_pos = !t_s4[T-1] && (t_s4 != '0);
	assign t_ge  = t_s4 >= $signed({2'b00, b_s4});

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= b_s4;
			num_s5 <= (t_pos && !t_ge) ? t_s4[B-1:0] : '0;
			if (!t_pos) begin
				region_s5 <= psp_pkg::REGION_START;
			end else if (t_ge) begin
				region_s5 <= psp_pkg::REGION_END;
			end else begin
				region_s5 <= psp_pkg::REGION_INTERIOR;
			end
			for (int i = 0; i < 3; i++) begin
				base_s5[i] <= (t_pos && t_ge) ? e_s4[i] : s_s4[i];
				q_s5[i]    <= q_s4[i];
				v_s5[i]    <= v_s4[i];
			end
		end
	end

	logic [DIV-1:0] frac;

	psp_divider #(
		.NUM_WIDTH(B)
	) u_div (
		.clk(clk),
		.en (en),
		.num(num_s5),
		.den(den_s5),
		.quo(frac)
	);

	logic signed [W-1:0] base_d [DIV][3];
	logic signed [W-1:0] q_d    [DIV][3];
	logic signed [V-1:0] v_d    [DIV][3];
	psp_pkg::region_t    reg_d  [DIV];

	// side data alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV; k++) begin
				if (k == 0) begin
					base_d[k] <= base_s5;
					q_d[k]    <= q_s5;
					v_d[k]    <= v_s5;
					reg_d[k]  <= region_s5;
				end else begin
					base_d[k] <= base_d[k-1];
					q_d[k]    <= q_d[k-1];
					v_d[k]    <= v_d[k-1];
					reg_d[k]  <= reg_d[k-1];
				end
			end
		end
	end

	logic signed [FW-1:0] prod_s6 [3];
	logic signed [W-1:0]  base_s6 [3], q_s6 [3];
	psp_pkg::region_t     region_s6;
	logic signed [FW-1:0] off [3];
	logic signed [W-1:0]  near_s7 [3], q_s7 [3];
	psp_pkg::region_t     region_s7;
	logic signed [V-1:0]  d [3];
	logic [P-1:0]         sq_s8 [3];
	logic signed [W-1:0]  near_s8 [3];
	psp_pkg::region_t     region_s8;
	logic [B-1:0]         sum_s9;
	logic signed [W-1:0]  near_s9 [3];
	psp_pkg::region_t     region_s9;

	// stage 6: fraction times segment vector
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= $signed({1'b0, frac}) * v_d[DIV-1][i];
				base_s6[i] <= base_d[DIV-1][i];
				q_s6[i]    <= q_d[DIV-1][i];
			end
			region_s6 <= reg_d[DIV-1];
		end
	end

	// stage 7: nearest point, offset floored toward minus infinity
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = prod_s6[i] >>> DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				near_s7[i] <= (region_s6 == psp_pkg::REGION_INTERIOR) ?
					base_s6[i] + off[i][W-1:0] : base_s6[i];
				q_s7[i] <= q_s6[i];
			end
			region_s7 <= region_s6;
		end
	end

	// stage 8: squared per-axis distance
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i] = V'(q_s7[i]) - V'(near_s7[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s8[i]   <= P'(d[i] * d[i]);
				near_s8[i] <= near_s7[i];
			end
			region_s8 <= region_s7;
		end
	end

	// stage 9: squared distance
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s9    <= B'(sq_s8[0]) + B'(sq_s8[1]) + B'(sq_s8[2]);
			near_s9   <= near_s8;
			region_s9 <= region_s8;
		end
	end

	logic [N-1:0] root;

	psp_isqrt #(
		.RAD_WIDTH(B)
	) u_sqrt (
		.clk (clk),
		.en  (en),
		.rad (sum_s9),
		.root(root)
	);

	logic signed [W-1:0] near_r [N][3];
	psp_pkg::region_t    reg_r  [N];

	// side data alongside the square root
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				if (k == 0) begin
					near_r[k] <= near_s9;
					reg_r[k]  <= region_s9;
				end else begin
					near_r[k] <= near_r[k-1];
					reg_r[k]  <= reg_r[k-1];
				end
			end
		end
	end

	logic signed [W-1:0] near_q [3];
	logic [N-1:0]        gap_q;
	psp_pkg::region_t    region_q;

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			near_q   <= near_r[N-1];
			gap_q    <= root;
			region_q <= reg_r[N-1];
		end
	end

	assign m_axis_tdata = OUT_BITS'({gap_q, near_q[2], near_q[1], near_q[0]});
	assign m_axis_tuser = region_q;

endmodule

// File: rtl/psp_divider.sv
// pipelined restoring divider, one quotient bit per stage, gives floor(num * 2^Q / den)
// depends on psp_pkg; requires num < den
module psp_divider #(
	parameter int NUM_WIDTH = 66
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [NUM_WIDTH-1:0]           num,
	input  logic [NUM_WIDTH-1:0]           den,
	output logic [psp_pkg::FRAC_BITS-1:0]  quo
);

	localparam int Q = psp_pkg::FRAC_BITS;

	logic [NUM_WIDTH-1:0] rem_s [Q];
	logic [NUM_WIDTH-1:0] den_s [Q];
	logic [Q-1:0]         quo_s [Q];

	logic [NUM_WIDTH-1:0] rin  [Q];
	logic [NUM_WIDTH-1:0] din  [Q];
	logic [Q-1:0]         qin  [Q];
	logic [NUM_WIDTH:0]   shl  [Q];
	logic [NUM_WIDTH:0]   diff [Q];
	logic                 fit  [Q];

	// per stage: shift remainder, trial subtract
	always_comb begin
		for (int k = 0; k < Q; k++) begin
			if (k == 0) begin
				rin[k] = num;
				din[k] = den;
				qin[k] = '0;
			end else begin
				rin[k] = rem_s[k-1];
				din[k] = den_s[k-1];
				qin[k] = quo_s[k-1];
			end
			shl[k]  = {rin[k], 1'b0};
			diff[k] = shl[k] - {1'b0, din[k]};
			fit[k]  = shl[k] >= {1'b0, din[k]};
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q; k++) begin
				rem_s[k] <= fit[k] ? diff[k][NUM_WIDTH-1:0] : shl[k][NUM_WIDTH-1:0];
				den_s[k] <= din[k];
				quo_s[k] <= {qin[k][Q-2:0], fit[k]};
			end
		end
	end

	assign quo = quo_s[Q-1];

endmodule

// File: rtl/psp_isqrt.sv
// pipelined integer square root, one root bit per stage, gives floor(sqrt(rad))
// depends on nothing; RAD_WIDTH must be even
module psp_isqrt #(
	parameter int RAD_WIDTH = 66
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [RAD_WIDTH-1:0]   rad,
	output logic [RAD_WIDTH/2-1:0] root
);

	localparam int N = RAD_WIDTH / 2;

	logic [RAD_WIDTH-1:0] op_s  [N];
	logic [RAD_WIDTH-1:0] res_s [N];

	logic [RAD_WIDTH-1:0] oin   [N];
	logic [RAD_WIDTH-1:0] rin   [N];
	logic [RAD_WIDTH-1:0] one   [N];
	logic [RAD_WIDTH-1:0] trial [N];
	logic                 fit   [N];

	// per stage: compare against res + one, settle one root bit
	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				oin[k] = rad;
				rin[k] = '0;
			end else begin
				oin[k] = op_s[k-1];
				rin[k] = res_s[k-1];
			end
			one[k]   = {{(RAD_WIDTH-1){1'b0}}, 1'b1} << (RAD_WIDTH - 2 - 2 * k);
			trial[k] = rin[k] + one[k];
			fit[k]   = oin[k] >= trial[k];
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				op_s[k]  <= fit[k] ? oin[k] - trial[k] : oin[k];
				res_s[k] <= fit[k] ? (rin[k] >> 1) + one[k] : rin[k] >> 1;
			end
		end
	end

	assign root = res_s[N-1][N-1:0];

endmodule

// File: rtl/psp_checker.sv
// port-level checks on the projection unit, attached by bind
// depends on point_segment_projection_distance_unit_assert.svh
`include "point_segment_projection_distance_unit_assert.svh"

module psp_port_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((4*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);

	localparam int OUT_USED = 4 * COORD_WIDTH + 1;

	// a stalled result holds
	`PSP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

	// a stalled result stops the input side
	`PSP_ASSERT_SAME(a_stall_back, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

	// empty output never blocks the input side
	`PSP_ASSERT_SAME(a_ready_free, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

	// pad bits of the result stay zero
	`PSP_ASSERT_SAME(a_pad_zero, m_axis_tvalid, (m_axis_tdata >> OUT_USED) == '0, "nonzero pad bits in result beat")

endmodule

bind point_segment_projection_distance_unit psp_port_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_psp_checker (.*);
